// File: hw/rtl/gbn_pkg.sv
// Package for the greedy box NMS unit: payload structs, state encoding, constants.
// No dependencies.
package gbn_pkg;
  localparam int GBN_MAX_BOXES = 64;
  localparam logic [15:0] GBN_THR_RESET = 16'd29491;

  typedef struct packed {
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] score;
    logic [7:0]  label;
    logic        set_end;
  } gbn_in_t;

  typedef struct packed {
    logic [15:0] kept_left;
    logic [15:0] kept_top;
    logic [15:0] kept_width;
    logic [15:0] kept_height;
    logic [15:0] kept_score;
    logic [7:0]  kept_label;
    logic        final_result;
    logic        overflowed;
  } gbn_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_LOAD, ST_RK_RD, ST_RK_GET, ST_RK_SCAN, ST_SEL_RD, ST_SEL_ORD,
    ST_SEL_CHK, ST_SUP_RD, ST_SUP_ORD, ST_SUP_LD, ST_SUP_WAIT, ST_SUP_CMP, ST_EMIT
  } gbn_state_t;

  typedef struct packed {
    logic        hit;
  } gbn_iou_res_t;
endpackage

// File: hw/rtl/gbn_iou.sv
// Pipelined IoU threshold test for two boxes: intersection, areas, multiply, compare.
// Depends on gbn_pkg. The inputs pass through the difference, product and hit registers.
module gbn_iou (
  input  logic        clk,
  input  logic [63:0] geo_a,
  input  logic [63:0] geo_b,
  input  logic [15:0] thr,
  output gbn_pkg::gbn_iou_res_t res
);
  import gbn_pkg::*;
  logic [16:0] x1, y1, x2, y2, ar, br, ab, bb;
  logic [16:0] dx_r, dy_r;
  logic        none_r;
  logic [15:0] aw_r, ah_r, bw_r, bh_r;
  logic [33:0] inter_r;
  logic [32:0] area_r;
  logic        none2_r;
  logic [49:0] lhs;
  logic [49:0] rhs;
  logic [33:0] uni;

  always_comb begin
    x1 = {1'b0, (geo_a[15:0] > geo_b[15:0]) ? geo_a[15:0] : geo_b[15:0]};
    y1 = {1'b0, (geo_a[31:16] > geo_b[31:16]) ? geo_a[31:16] : geo_b[31:16]};
    ar = {1'b0, geo_a[15:0]} + {1'b0, geo_a[47:32]};
    br = {1'b0, geo_b[15:0]} + {1'b0, geo_b[47:32]};
    ab = {1'b0, geo_a[31:16]} + {1'b0, geo_a[63:48]};
    bb = {1'b0, geo_b[31:16]} + {1'b0, geo_b[63:48]};
    x2 = (ar < br) ? ar : br;
    y2 = (ab < bb) ? ab : bb;
  end

  always_ff @(posedge clk) begin
    none_r <= (x2 <= x1) || (y2 <= y1);
    dx_r   <= x2 - x1;
    dy_r   <= y2 - y1;
    aw_r <= geo_a[47:32]; ah_r <= geo_a[63:48];
    bw_r <= geo_b[47:32]; bh_r <= geo_b[63:48];
    inter_r <= dx_r * dy_r;
    area_r  <= 33'({16'd0, aw_r} * {16'd0, ah_r}) + 33'({16'd0, bw_r} * {16'd0, bh_r});
    none2_r <= none_r;
  end

  always_comb begin
    uni = {1'b0, area_r} - inter_r;
    lhs = {inter_r[33:0], 16'd0};
    rhs = uni * 50'(thr);
  end

  always_ff @(posedge clk) begin
    res.hit <= !none2_r && (lhs > rhs);
  end
endmodule

// File: hw/rtl/greedy_box_nms_unit.sv
// Top level of the greedy box NMS unit: load memories, rank sort, suppression pass, emit.
// Depends on gbn_pkg and gbn_iou.
//
//  channel | direction | handshake      | word
//  in_     | input     | valid / stall  | gbn_in_t box
//  out_    | output    | valid / stall  | gbn_out_t kept box
//  cfg_    | input     | valid / ready  | 16-bit IoU threshold
//
// Boxes load one per cycle. After the set_end word, each box is ranked by a scan of all boxes.
// The pass then reads boxes in rank order; for each kept box it reads every later box, tests
// the unsuppressed ones, then emits the kept box; a last read ends the pass. An output stall holds the emit.
// A clear of all MAX_BOXES marks follows; input stalls from set_end to
// its end. Reset is synchronous and starts with that clear; cfg_ready is high only in load.
module greedy_box_nms_unit #(
  parameter int MAX_BOXES = gbn_pkg::GBN_MAX_BOXES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  gbn_pkg::gbn_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output gbn_pkg::gbn_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);
  import gbn_pkg::*;
  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);

  logic [63:0]   geo_mem [MAX_BOXES];
  logic [23:0]   sl_mem  [MAX_BOXES];
  logic [AW-1:0] ord_mem [MAX_BOXES];
  logic          sup_mem [MAX_BOXES];

  gbn_state_t    state_r, state_nxt;
  logic [15:0]   thr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, rank_r, rank_nxt;
  logic [15:0]   s_r, s_nxt;
  logic          any_r, any_nxt;
  logic [1:0]    wait_r, wait_nxt;

  logic [AW-1:0] ord_ra, ord_wa, geo_ra, sl_ra, sup_ra, sup_wa;
  logic [AW-1:0] ord_rdata_r;
  logic [63:0]   geo_rdata_r, geo_a_r, geo_a_nxt, geo_b_r, geo_b_nxt;
  logic [23:0]   sl_rdata_r, sl_a_r, sl_a_nxt;
  logic          sup_rdata_r;
  logic          ord_we, sup_we, sup_wv, load_we;
  logic [AW-1:0] ord_wd;
  logic [AW-1:0] b_r, b_nxt;
  logic          sup_b_r, sup_b_nxt;
  gbn_out_t      obuf_r, obuf_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic          out_free, scan_inc, scan_last;
  logic [CW-1:0] cnt_m1, rank_inc;
  gbn_iou_res_t  iou;

  gbn_iou u_iou (.clk(clk), .geo_a(geo_a_r), .geo_b(geo_b_r), .thr(thr_r), .res(iou));

  always_ff @(posedge clk) begin
    if (load_we) begin
      geo_mem[cnt_r[AW-1:0]] <= {in_data.box_height, in_data.box_width,
                                 in_data.box_top, in_data.box_left};
      sl_mem[cnt_r[AW-1:0]]  <= {in_data.label, in_data.score};
    end
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (sup_we) sup_mem[sup_wa] <= sup_wv;
    geo_rdata_r <= geo_mem[geo_ra];
    sl_rdata_r  <= sl_mem[sl_ra];
    ord_rdata_r <= ord_mem[ord_ra];
    sup_rdata_r <= sup_mem[sup_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; thr_r <= GBN_THR_RESET; cnt_r <= '0; ovf_r <= 1'b0;
      i_r <= '0; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; i_r <= i_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_valid && cfg_ready) thr_r <= cfg_data;
    end
    j_r <= j_nxt; k_r <= k_nxt; rank_r <= rank_nxt; s_r <= s_nxt; any_r <= any_nxt;
    wait_r <= wait_nxt; geo_a_r <= geo_a_nxt; geo_b_r <= geo_b_nxt; sl_a_r <= sl_a_nxt;
    b_r <= b_nxt; sup_b_r <= sup_b_nxt; obuf_r <= obuf_nxt;
  end

  assign cfg_ready = (state_r == ST_LOAD);
  assign in_stall  = (state_r != ST_LOAD);
  assign out_valid = ovalid_r;
  assign out_data  = obuf_r;
  assign out_free  = !ovalid_r || !out_stall;
  assign cnt_m1    = cnt_r - 1'b1;
  assign scan_inc  = (sl_rdata_r[15:0] > s_r) || ((sl_rdata_r[15:0] == s_r) && (k_r < i_r));
  assign scan_last = (k_r == cnt_m1);
  assign rank_inc  = rank_r + CW'(scan_inc);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (i_r == CW'(MAX_BOXES - 1)) state_nxt = ST_LOAD;
      ST_LOAD:     if (in_valid && in_data.set_end) state_nxt = ST_RK_RD;
      ST_RK_RD:    state_nxt = ST_RK_GET;
      ST_RK_GET:   state_nxt = ST_RK_SCAN;
      ST_RK_SCAN:  if (scan_last) state_nxt = (i_r == cnt_m1) ? ST_SEL_RD : ST_RK_RD;
      ST_SEL_RD:   state_nxt = (i_r == cnt_r) ? ST_CLEAR : ST_SEL_ORD;
      ST_SEL_ORD:  state_nxt = ST_SEL_CHK;
      ST_SEL_CHK:  state_nxt = sup_rdata_r ? ST_SEL_RD : ST_SUP_RD;
      ST_SUP_RD:   state_nxt = (j_r == cnt_r) ? ST_EMIT : ST_SUP_ORD;
      ST_SUP_ORD:  state_nxt = ST_SUP_LD;
      ST_SUP_LD:   state_nxt = ST_SUP_WAIT;
      ST_SUP_WAIT: if (wait_r == 2'd0) state_nxt = ST_SUP_CMP;
      ST_SUP_CMP:  state_nxt = ST_SUP_RD;
      ST_EMIT:     if (out_free) state_nxt = ST_SEL_RD;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  // Datapath and output control.
  always_comb begin
    cnt_nxt = cnt_r; ovf_nxt = ovf_r; i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    rank_nxt = rank_r; s_nxt = s_r; any_nxt = any_r; wait_nxt = wait_r;
    geo_a_nxt = geo_a_r; geo_b_nxt = geo_b_r; sl_a_nxt = sl_a_r; b_nxt = b_r;
    sup_b_nxt = sup_b_r; obuf_nxt = obuf_r; ovalid_nxt = ovalid_r && out_stall;
    load_we = 1'b0; ord_we = 1'b0; ord_wa = '0; ord_wd = '0;
    sup_we = 1'b0; sup_wa = '0; sup_wv = 1'b0;
    ord_ra = '0; geo_ra = '0; sl_ra = '0; sup_ra = '0;
    case (state_r)
      ST_CLEAR: begin
        sup_we = 1'b1; sup_wa = i_r[AW-1:0];
        if (i_r == CW'(MAX_BOXES - 1)) begin
          i_nxt = '0; cnt_nxt = '0; ovf_nxt = 1'b0;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CW'(MAX_BOXES)) begin
            load_we = 1'b1; cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.set_end) i_nxt = '0;
        end
      end
      ST_RK_RD: begin
        sl_ra = i_r[AW-1:0];
      end
      ST_RK_GET: begin
        s_nxt = sl_rdata_r[15:0]; sl_ra = '0; k_nxt = '0; rank_nxt = '0;
      end
      ST_RK_SCAN: begin
        // The rank of box i counts boxes with a higher score or an equal score loaded earlier.
        sl_ra = AW'(k_r + 1'b1);
        rank_nxt = rank_inc;
        k_nxt = k_r + 1'b1;
        if (scan_last) begin
          ord_we = 1'b1; ord_wa = rank_inc[AW-1:0]; ord_wd = i_r[AW-1:0];
          i_nxt = (i_r == cnt_m1) ? '0 : i_r + 1'b1;
        end
      end
      ST_SEL_RD: begin
        ord_ra = i_r[AW-1:0];
        j_nxt = i_r + 1'b1;
        if (i_r == cnt_r) i_nxt = '0;
      end
      ST_SEL_ORD: begin
        geo_ra = ord_rdata_r; sl_ra = ord_rdata_r; sup_ra = ord_rdata_r;
      end
      ST_SEL_CHK: begin
        if (sup_rdata_r) begin
          i_nxt = i_r + 1'b1;
        end else begin
          geo_a_nxt = geo_rdata_r; sl_a_nxt = sl_rdata_r; any_nxt = 1'b0;
        end
      end
      ST_SUP_RD: begin
        ord_ra = j_r[AW-1:0];
      end
      ST_SUP_ORD: begin
        b_nxt = ord_rdata_r; geo_ra = ord_rdata_r; sup_ra = ord_rdata_r;
      end
      ST_SUP_LD: begin
        geo_b_nxt = geo_rdata_r; sup_b_nxt = sup_rdata_r; wait_nxt = 2'd2;
      end
      ST_SUP_WAIT: begin
        wait_nxt = wait_r - 1'b1;
      end
      ST_SUP_CMP: begin
        // A later box left unsuppressed will be kept, so the current box is not the final one.
        if (!sup_b_r) begin
          if (iou.hit) begin
            sup_we = 1'b1; sup_wa = b_r; sup_wv = 1'b1;
          end else begin
            any_nxt = 1'b1;
          end
        end
        j_nxt = j_r + 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          obuf_nxt.kept_left    = geo_a_r[15:0];
          obuf_nxt.kept_top     = geo_a_r[31:16];
          obuf_nxt.kept_width   = geo_a_r[47:32];
          obuf_nxt.kept_height  = geo_a_r[63:48];
          obuf_nxt.kept_score   = sl_a_r[15:0];
          obuf_nxt.kept_label   = sl_a_r[23:16];
          obuf_nxt.final_result = !any_r;
          obuf_nxt.overflowed   = ovf_r;
          i_nxt = i_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data));
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_BOXES));
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !in_stall);
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(out_valid));
endmodule

// File: tb/greedy_box_nms_unit_test.sv
// Testbench for greedy_box_nms_unit: drives box sets, predicts kept boxes by greedy NMS.
// Depends on gbn_pkg and the greedy_box_nms_unit RTL.
module greedy_box_nms_unit_test;
  import gbn_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  gbn_in_t in_data;
  logic out_valid;
  logic out_stall;
  gbn_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;

  greedy_box_nms_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state.
  logic [63:0] geo_mem [GBN_MAX_BOXES];
  logic [23:0] sl_mem [GBN_MAX_BOXES];
  int          box_count;
  logic        lost_boxes;
  logic [15:0] thr;

  gbn_out_t exp_words [4096];
  int  exp_wr;
  int  exp_rd;
  int  mismatches;
  logic in_gaps;
  logic out_gaps;
  int  hold_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic too_close(logic [63:0] ga, logic [63:0] gb);
    logic [16:0] al, at, aw, ah, bl, bt, bw, bh, x1, y1, x2, y2;
    logic [63:0] inter, uni;
    al = ga[15:0]; at = ga[31:16]; aw = ga[47:32]; ah = ga[63:48];
    bl = gb[15:0]; bt = gb[31:16]; bw = gb[47:32]; bh = gb[63:48];
    x1 = al > bl ? al : bl;
    y1 = at > bt ? at : bt;
    x2 = (al + aw) < (bl + bw) ? (al + aw) : (bl + bw);
    y2 = (at + ah) < (bt + bh) ? (at + ah) : (bt + bh);
    if (x2 <= x1 || y2 <= y1) return 1'b0;
    inter = 64'(x2 - x1) * 64'(y2 - y1);
    uni = 64'(aw) * 64'(ah) + 64'(bw) * 64'(bh) - inter;
    return (inter << 16) > 64'(thr) * uni;
  endfunction

  task automatic predict_box(gbn_in_t b);
    int order [GBN_MAX_BOXES];
    logic gone [GBN_MAX_BOXES];
    int i, j, a, last;
    gbn_out_t r;
    if (box_count < GBN_MAX_BOXES) begin
      geo_mem[box_count] = {b.box_height, b.box_width, b.box_top, b.box_left};
      sl_mem[box_count] = {b.label, b.score};
      box_count++;
    end else begin
      lost_boxes = 1'b1;
    end
    if (!b.set_end) return;
    for (i = 0; i < box_count; i++) begin
      gone[i] = 1'b0;
      j = i;
      while (j > 0 && sl_mem[order[j-1]][15:0] < sl_mem[i][15:0]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    last = -1;
    for (i = 0; i < box_count; i++) begin
      a = order[i];
      if (gone[a]) continue;
      r.kept_left = geo_mem[a][15:0];
      r.kept_top = geo_mem[a][31:16];
      r.kept_width = geo_mem[a][47:32];
      r.kept_height = geo_mem[a][63:48];
      r.kept_score = sl_mem[a][15:0];
      r.kept_label = sl_mem[a][23:16];
      r.final_result = 1'b0;
      r.overflowed = lost_boxes;
      exp_words[exp_wr] = r;
      last = exp_wr;
      exp_wr++;
      for (j = i + 1; j < box_count; j++)
        if (!gone[order[j]] && too_close(geo_mem[a], geo_mem[order[j]]))
          gone[order[j]] = 1'b1;
    end
    if (last >= 0) exp_words[last].final_result = 1'b1;
    box_count = 0;
    lost_boxes = 1'b0;
  endtask

  task automatic send_box(gbn_in_t b);
    int gap;
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_box(b);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (exp_rd != exp_wr && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_thr(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    thr = v;
  endtask

  function automatic gbn_in_t rand_box(logic last, int mode);
    gbn_in_t b;
    b.box_left = 16'($urandom); b.box_top = 16'($urandom);
    b.box_width = 16'($urandom); b.box_height = 16'($urandom);
    if (mode == 1) begin
      // Clustered boxes so that overlaps are common.
      b.box_left = 16'($urandom_range(0, 400)); b.box_top = 16'($urandom_range(0, 400));
      b.box_width = 16'($urandom_range(0, 600)); b.box_height = 16'($urandom_range(0, 600));
    end
    b.score = (mode == 1) ? 16'($urandom_range(0, 15) * 4096) : 16'($urandom);
    b.label = 8'($urandom);
    b.set_end = last;
    return b;
  endfunction

  task automatic send_set(int n, int mode);
    int k;
    for (k = 0; k < n; k++) send_box(rand_box(k == n - 1, mode));
  endtask

  task automatic test_directed();
    gbn_in_t b;
    // Single-box sets: an all-zero box of zero size, then a box with every field at its maximum.
    b = '0; b.set_end = 1'b1; send_box(b);
    b = '1; send_box(b);
    // Identical boxes, equal scores: load order decides.
    b = '{16'd100, 16'd100, 16'd50, 16'd50, 16'd5, 8'd1, 1'b0}; send_box(b);
    b.label = 8'd2; send_box(b);
    b.score = 16'd9; b.label = 8'd3; send_box(b);
    b = '{16'd1000, 16'd1000, 16'd20, 16'd20, 16'd7, 8'd4, 1'b0}; send_box(b);
    b = '{16'd105, 16'd100, 16'd50, 16'd50, 16'd6, 8'd5, 1'b0}; send_box(b);
    // Edges past the top of the range.
    b = '{16'hFFF0, 16'hFFF0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0}; send_box(b);
    b = '{16'hFFF8, 16'hFFF8, 16'hFFFF, 16'hFFFF, 16'h0000, 8'h00, 1'b1}; send_box(b);
    drain();
  endtask

  task automatic test_overflow();
    gbn_in_t b;
    int k;
    for (k = 0; k < GBN_MAX_BOXES + 3; k++) begin
      b = rand_box(k == GBN_MAX_BOXES + 2, 0);
      send_box(b);
    end
    drain();
  endtask

  task automatic test_thresholds();
    write_thr(16'd0);
    send_set(8, 1);
    drain();
    write_thr(16'hFFFF);
    send_set(8, 1);
    drain();
    write_thr(GBN_THR_RESET);
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    send_set(20, 1);
    send_set(5, 1);
    drain();
  endtask

  task automatic test_random();
    int sent, n;
    sent = 0;
    while (sent < 340) begin
      if ($urandom_range(0, 9) == 0) begin
        drain();
        write_thr(16'($urandom));
      end
      n = ($urandom_range(0, 15) == 0) ? int'($urandom_range(30, 64)) :
                                         int'($urandom_range(1, 10));
      send_set(n, $urandom_range(0, 3) == 0 ? 0 : 1);
      sent += n;
      if (sent > 290) begin
        in_gaps = 1'b0;
        out_gaps = 1'b0;
      end
    end
    drain();
  endtask

  // Receiver stall generator.
  initial begin
    int burst;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (out_gaps && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    gbn_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_rd == exp_wr) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word %h", out_data);
      end else begin
        want = exp_words[exp_rd];
        exp_rd++;
        if (out_data.kept_left !== want.kept_left || out_data.kept_top !== want.kept_top ||
            out_data.kept_width !== want.kept_width ||
            out_data.kept_height !== want.kept_height ||
            out_data.kept_score !== want.kept_score ||
            out_data.kept_label !== want.kept_label ||
            out_data.final_result !== want.final_result ||
            out_data.overflowed !== want.overflowed) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %h actual %h", want, out_data);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    exp_wr = 0;
    exp_rd = 0;
    box_count = 0;
    lost_boxes = 1'b0;
    thr = GBN_THR_RESET;
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_thresholds();
    test_backpressure();
    test_random();
    if (mismatches == 0 && exp_rd == exp_wr) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: greedy_box_nms_unit.f
hw/rtl/gbn_pkg.sv
hw/rtl/gbn_iou.sv
hw/rtl/greedy_box_nms_unit.sv
tb/greedy_box_nms_unit_test.sv
